### design/fast_corner_segment_test_defines.svh
// assertion helpers shared by the corner test modules
`ifndef FAST_CORNER_SEGMENT_TEST_DEFINES_SVH
`define FAST_CORNER_SEGMENT_TEST_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FCST_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FCST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fcst_pkg.sv
package fcst_pkg;

    // ring geometry
    localparam int RING_SIZE     = 16;
    localparam int COMPASS_COUNT = 4;
    localparam int CELL_COUNT    = 2 * RING_SIZE - 1;

    // field widths
    localparam int PIX_W       = 8;
    localparam int HALF_W      = (RING_SIZE / 2) * PIX_W;
    localparam int DIFF_W      = PIX_W + 1;
    localparam int SCORE_W     = 13;
    localparam int RUN_W       = 5;
    localparam int CNEED_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // register reset values and limits
    localparam logic [PIX_W-1:0]   THR_RESET   = 8'd10;
    localparam logic [RUN_W-1:0]   ARC_RESET   = 5'd12;
    localparam logic [RUN_W-1:0]   ARC_MAX     = RUN_W'(RING_SIZE);
    localparam logic [CNEED_W-1:0] CNEED_RESET = 3'd3;
    localparam logic [CNEED_W-1:0] CNEED_MAX   = CNEED_W'(COMPASS_COUNT);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD      = 2'd0,
        CFG_ARC_LENGTH     = 2'd1,
        CFG_COMPASS_NEEDED = 2'd2
    } cfg_index_t;

    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    // one classified ring pixel
    typedef struct packed {
        logic  up;
        logic  dn;
        diff_t diff;
    } pix_t;

    // scan state handed from cell to cell
    typedef struct packed {
        logic                  done;
        logic [RUN_W-1:0]      n_up;
        logic [RUN_W-1:0]      n_dn;
        score_t                s_up;
        score_t                s_dn;
        score_t                score;
        pix_t [RING_SIZE-1:0]  pix;
    } scan_t;

    // compass pixels in cyclic order
    function automatic int compass_pos(input int k);
        int pos;
        case (k)
            0:       pos = 13;
            1:       pos = 1;
            2:       pos = 5;
            default: pos = 9;
        endcase
        return pos;
    endfunction

endpackage

### design/fast_corner_segment_test.sv
// throughput: one word per cycle while no stage stalls; one classify stage, 31 ring scan cells, one output stage
// every stage holds under stall and takes a new word as soon as its successor moves
// reset: asynchronous, active low; clears all valid flags, diff_threshold to 10,
// arc_length to 12 and compass_needed to 3
`include "fast_corner_segment_test_defines.svh"

module fast_corner_segment_test (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [fcst_pkg::PIX_W-1:0]            center_pixel,
    input  logic [fcst_pkg::HALF_W-1:0]           ring_first_half,
    input  logic [fcst_pkg::HALF_W-1:0]           ring_second_half,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fcst_pkg::SCORE_W-1:0]   corner_score,
    output logic                                  is_corner,
    input  logic                                  cfg_write,
    input  logic [fcst_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fcst_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fcst_pkg::*;

    logic [PIX_W-1:0]   thr_reg;
    logic [RUN_W-1:0]   arc_reg;
    logic [CNEED_W-1:0] cneed_reg;
    logic [RUN_W-1:0]   arc_eff;
    logic [CNEED_W-1:0] cneed_eff;

    logic [CELL_COUNT:0] chain_valid;
    logic [CELL_COUNT:0] chain_stall;
    scan_t               chain_scan [CELL_COUNT+1];

    logic   out_valid_reg;
    score_t corner_score_reg;
    logic   is_corner_reg;
    logic   out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            arc_reg   <= ARC_RESET;
            cneed_reg <= CNEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:      thr_reg   <= cfg_data[PIX_W-1:0];
                CFG_ARC_LENGTH:     arc_reg   <= cfg_data[RUN_W-1:0];
                CFG_COMPASS_NEEDED: cneed_reg <= cfg_data[CNEED_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamp run lengths into their legal ranges
    always_comb
    begin
        if (arc_reg == '0)
            arc_eff = RUN_W'(1);
        else if (arc_reg > ARC_MAX)
            arc_eff = ARC_MAX;
        else
            arc_eff = arc_reg;

        if (cneed_reg == '0)
            cneed_eff = CNEED_W'(1);
        else if (cneed_reg > CNEED_MAX)
            cneed_eff = CNEED_MAX;
        else
            cneed_eff = cneed_reg;
    end

    // classify ring pixels and apply the quick gate
    fcst_classify u_classify (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .center_pixel     (center_pixel),
        .ring_first_half  (ring_first_half),
        .ring_second_half (ring_second_half),
        .thr              (thr_reg),
        .cneed            (cneed_eff),
        .out_valid        (chain_valid[0]),
        .out_stall        (chain_stall[0]),
        .scan_out         (chain_scan[0])
    );

    // scan cells, one ring position each, wrapping once around the ring
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        fcst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_stall  (chain_stall[i]),
            .scan_in   (chain_scan[i]),
            .cur       (chain_scan[i].pix[i % RING_SIZE]),
            .arc_len   (arc_eff),
            .out_valid (chain_valid[i+1]),
            .out_stall (chain_stall[i+1]),
            .scan_out  (chain_scan[i+1])
        );
    end

    // output register
    assign chain_stall[CELL_COUNT] = out_valid_reg & out_stall;
    assign out_load = chain_valid[CELL_COUNT] & ~chain_stall[CELL_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!chain_stall[CELL_COUNT])
        begin
            out_valid_reg <= chain_valid[CELL_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            corner_score_reg <= chain_scan[CELL_COUNT].score;
            is_corner_reg    <= chain_scan[CELL_COUNT].score != '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign corner_score = corner_score_reg;
    assign is_corner    = is_corner_reg;

    // corner flag agrees with the score
    `FCST_ASSERT_NOW(a_top_flag, out_valid_reg,
        is_corner_reg == (corner_score_reg != '0),
        "corner flag disagrees with score")
    // last cell word lands in the output register
    `FCST_ASSERT_NEXT(a_top_land, out_load,
        out_valid_reg && (corner_score_reg == $past(chain_scan[CELL_COUNT].score)),
        "output register lost a word")
    // the last cell is held back only while the output holds a word
    `FCST_ASSERT_NOW(a_top_hold, chain_stall[CELL_COUNT],
        out_valid_reg && out_stall,
        "last cell stalled without a waiting word")

endmodule

### design/fcst_classify.sv
module fcst_classify (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fcst_pkg::PIX_W-1:0]    center_pixel,
    input  logic [fcst_pkg::HALF_W-1:0]   ring_first_half,
    input  logic [fcst_pkg::HALF_W-1:0]   ring_second_half,
    input  logic [fcst_pkg::PIX_W-1:0]    thr,
    input  logic [fcst_pkg::CNEED_W-1:0]  cneed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output fcst_pkg::scan_t               scan_out
);
    import fcst_pkg::*;

    logic                    valid_reg;
    scan_t                   scan_reg;
    scan_t                   scan_next;
    logic [PIX_W-1:0]        ring_px [RING_SIZE];
    pix_t [RING_SIZE-1:0]    pix;
    logic [COMPASS_COUNT-1:0] cp_up;
    logic [COMPASS_COUNT-1:0] cp_dn;
    logic                    gate;
    diff_t                   thr_pos;
    diff_t                   thr_neg;

    // unpack ring words
    always_comb
    begin
        for (int k = 0; k < RING_SIZE / 2; k++)
        begin
            ring_px[k]                 = ring_first_half[PIX_W*k +: PIX_W];
            ring_px[k + RING_SIZE / 2] = ring_second_half[PIX_W*k +: PIX_W];
        end
    end

    // difference and polarity of every ring pixel
    always_comb
    begin
        thr_pos = diff_t'({1'b0, thr});
        thr_neg = -thr_pos;
        for (int k = 0; k < RING_SIZE; k++)
        begin
            pix[k].diff = diff_t'({1'b0, ring_px[k]}) - diff_t'({1'b0, center_pixel});
            pix[k].up   = pix[k].diff > thr_pos;
            pix[k].dn   = pix[k].diff < thr_neg;
        end
    end

    // quick gate over the compass pixels with wraparound
    always_comb
    begin
        logic all_up;
        logic all_dn;
        gate = 1'b0;
        for (int k = 0; k < COMPASS_COUNT; k++)
        begin
            cp_up[k] = pix[compass_pos(k)].up;
            cp_dn[k] = pix[compass_pos(k)].dn;
        end
        for (int s = 0; s < COMPASS_COUNT; s++)
        begin
            all_up = 1'b1;
            all_dn = 1'b1;
            for (int j = 0; j < COMPASS_COUNT; j++)
            begin
                if (CNEED_W'(j) < cneed)
                begin
                    all_up = all_up & cp_up[(s + j) % COMPASS_COUNT];
                    all_dn = all_dn & cp_dn[(s + j) % COMPASS_COUNT];
                end
            end
            gate = gate | all_up | all_dn;
        end
    end

    // fresh scan state; a failed gate is finished with a zero score
    always_comb
    begin
        scan_next.done  = ~gate;
        scan_next.n_up  = '0;
        scan_next.n_dn  = '0;
        scan_next.s_up  = '0;
        scan_next.s_dn  = '0;
        scan_next.score = '0;
        scan_next.pix   = pix;
    end

    // stage handshake
    assign in_stall  = valid_reg & out_stall;
    assign out_valid = valid_reg;
    assign scan_out  = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            scan_reg <= scan_next;
        end
    end

endmodule

### design/fcst_cell.sv
`include "fast_corner_segment_test_defines.svh"

module fcst_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  fcst_pkg::scan_t             scan_in,
    input  fcst_pkg::pix_t              cur,
    input  logic [fcst_pkg::RUN_W-1:0]  arc_len,
    output logic                        out_valid,
    input  logic                        out_stall,
    output fcst_pkg::scan_t             scan_out
);
    import fcst_pkg::*;

    logic             valid_reg;
    scan_t            scan_reg;
    scan_t            scan_next;
    logic [RUN_W-1:0] n_up_inc;
    logic [RUN_W-1:0] n_dn_inc;
    score_t           sum_up;
    score_t           sum_dn;

    // extend the running runs by this cell's ring pixel
    always_comb
    begin
        n_up_inc  = scan_in.n_up + RUN_W'(1);
        n_dn_inc  = scan_in.n_dn + RUN_W'(1);
        sum_up    = scan_in.s_up + score_t'(cur.diff);
        sum_dn    = scan_in.s_dn + score_t'(cur.diff);
        scan_next = scan_in;
        if (!scan_in.done)
        begin
            if (cur.up)
            begin
                scan_next.n_up = n_up_inc;
                scan_next.s_up = sum_up;
                scan_next.n_dn = '0;
                scan_next.s_dn = '0;
                if (n_up_inc >= arc_len)
                begin
                    scan_next.done  = 1'b1;
                    scan_next.score = sum_up;
                end
            end
            else if (cur.dn)
            begin
                scan_next.n_dn = n_dn_inc;
                scan_next.s_dn = sum_dn;
                scan_next.n_up = '0;
                scan_next.s_up = '0;
                if (n_dn_inc >= arc_len)
                begin
                    scan_next.done  = 1'b1;
                    scan_next.score = sum_dn;
                end
            end
            else
            begin
                scan_next.n_up = '0;
                scan_next.n_dn = '0;
                scan_next.s_up = '0;
                scan_next.s_dn = '0;
            end
        end
    end

    // stage handshake
    assign in_stall  = valid_reg & out_stall;
    assign out_valid = valid_reg;
    assign scan_out  = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            scan_reg <= scan_next;
        end
    end

    // a finished scan passes through untouched
    `FCST_ASSERT_NEXT(a_cell_done_hold, in_valid && !in_stall && scan_in.done,
        scan_reg.done && (scan_reg.score == $past(scan_in.score)),
        "finished scan changed in cell")
    // only one polarity run can be open
    `FCST_ASSERT_NOW(a_cell_one_pol, valid_reg,
        (scan_reg.n_up == '0) || (scan_reg.n_dn == '0),
        "both polarity runs open")
    // the score is set only when a run completes
    `FCST_ASSERT_NOW(a_cell_open_zero, valid_reg && !scan_reg.done,
        scan_reg.score == '0,
        "open scan carries a score")

endmodule
